/* rtl/gdx_pkg.sv */
// Shared types, constants and helpers for the grid index converter.
package gdx_pkg;

	localparam int DIMENSIONS = 3;
	localparam int RES_BITS   = 10;
	localparam int RES_W      = 11;
	localparam int CELL_W     = 30;
	localparam int COORD_W    = 10;
	localparam int STRIDE_W   = 21;
	localparam int TOTAL_W    = 31;
	localparam int CELLS      = 2 * COORD_W;

	localparam logic [1:0] REG_RES_DIM_0 = 2'd0;
	localparam logic [1:0] REG_RES_DIM_1 = 2'd1;
	localparam logic [1:0] REG_RES_DIM_2 = 2'd2;

	localparam logic OP_SPLIT   = 1'b0;
	localparam logic OP_COMBINE = 1'b1;

	localparam logic [RES_W-1:0] RES_RESET = RES_W'(1024);
	localparam logic [RES_W-1:0] RES_TOP   = RES_W'(1 << RES_BITS);

	typedef struct packed {
		logic               operation;
		logic [CELL_W-1:0]  cell_number;
		logic [COORD_W-1:0] coord_zero;
		logic [COORD_W-1:0] coord_one;
		logic [COORD_W-1:0] coord_two;
	} req_t;

	typedef struct packed {
		logic [CELL_W-1:0]  out_cell_number;
		logic [COORD_W-1:0] out_coord_zero;
		logic [COORD_W-1:0] out_coord_one;
		logic [COORD_W-1:0] out_coord_two;
		logic               out_of_range;
	} rsp_t;

	typedef struct packed {
		logic               op;
		logic               oor;
		logic [CELL_W-1:0]  acc;
		logic [COORD_W-1:0] x0;
		logic [COORD_W-1:0] x1;
		logic [COORD_W-1:0] x2;
	} work_t;

	function automatic logic [RES_W-1:0] eff_res(input logic [RES_W-1:0] r, input int axis);
		logic [RES_W-1:0] v;
		v = r;
		if (axis >= DIMENSIONS) v = RES_W'(1);
		else if (r == '0) v = RES_W'(1);
		else if (r > RES_TOP) v = RES_TOP;
		return v;
	endfunction

endpackage

/* rtl/gdx_front.sv */
// Entry stages: capture item, check coordinates, check cell number against the cell count.
module gdx_front import gdx_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  req_t                in_item,
	input  logic [RES_W-1:0]    eff0,
	input  logic [RES_W-1:0]    eff1,
	input  logic [RES_W-1:0]    eff2,
	input  logic [TOTAL_W-1:0]  total,
	output logic                out_valid,
	input  logic                out_ready,
	output work_t               out_item
);
	logic  v_s1, v_s2, v_s3;
	req_t  d_s1;
	work_t d_s2, d_s3;
	logic  en1, en2, en3;
	work_t n2, n3;

	assign en3 = !v_s3 || out_ready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	always_comb begin
		n2.op  = d_s1.operation;
		n2.x0  = d_s1.coord_zero;
		if (d_s1.operation == OP_COMBINE) begin
			n2.acc = '0;
			n2.x1  = d_s1.coord_one;
			n2.x2  = d_s1.coord_two;
			n2.oor = ({1'b0, d_s1.coord_zero} >= eff0) || ({1'b0, d_s1.coord_one} >= eff1)
				|| ({1'b0, d_s1.coord_two} >= eff2);
		end else begin
			n2.acc = d_s1.cell_number;
			n2.x1  = '0;
			n2.x2  = '0;
			n2.oor = 1'b0;
		end
		n3 = d_s2;
		if (d_s2.op == OP_SPLIT) n3.oor = ({1'b0, d_s2.acc} >= total);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) d_s1 <= in_item;
		if (en2 && v_s1) d_s2 <= n2;
		if (en3 && v_s2) d_s3 <= n3;
	end

	assign out_valid = v_s3;
	assign out_item  = d_s3;
endmodule

/* rtl/gdx_cell.sv */
// One digit step: a restoring division bit for a split, a shift-add bit for a combine.
module gdx_cell import gdx_pkg::*; #(
	parameter int DIM = 2,
	parameter int BIT = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [STRIDE_W-1:0] stride,
	input  logic                in_valid,
	output logic                in_ready,
	input  work_t               in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output work_t               out_item
);
	logic              valid_q;
	work_t             item_q;
	work_t             nxt;
	logic [CELL_W+1:0] step;
	logic [CELL_W+1:0] diff;
	logic [COORD_W-1:0] sel;
	logic              en;

	assign en = !valid_q || out_ready;
	assign in_ready = en;
	assign step = (CELL_W+2)'(stride) << BIT;
	assign diff = {2'b00, in_item.acc} - step;
	assign sel  = (DIM == 2) ? in_item.x2 : in_item.x1;

	always_comb begin
		nxt = in_item;
		if (in_item.op == OP_SPLIT) begin
			if (!diff[CELL_W+1]) begin
				nxt.acc = diff[CELL_W-1:0];
				if (DIM == 2) nxt.x2[BIT] = 1'b1;
				else nxt.x1[BIT] = 1'b1;
			end
		end else if (sel[BIT]) begin
			nxt.acc = in_item.acc + step[CELL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) item_q <= nxt;
	end

	assign out_valid = valid_q;
	assign out_item  = item_q;
endmodule

/* rtl/grid_index_coord_convert.sv */
// Top level: resolution registers, entry stages, chain of digit cells and result register.
// Registers from request to result: 24 (3 entry, 20 cells, 1 output).
// Throughput: one item per cycle while rsp_ready is high; each stage holds one item, stalls if full.
// The cell count is two multiplier stages behind the resolution registers.
// Reset: asynchronous, active low; clears all valid bits and sets resolutions to 1024.
module grid_index_coord_convert import gdx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output rsp_t        rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [RES_W-1:0]    res0_q, res1_q, res2_q;
	logic [RES_W-1:0]    eff0, eff1, eff2;
	logic [STRIDE_W-1:0] stride2_q;
	logic [TOTAL_W-1:0]  total_q;
	logic                wr;

	logic  v   [0:CELLS];
	logic  rdy [0:CELLS];
	work_t w   [0:CELLS];

	logic  out_valid_q;
	rsp_t  out_q;
	rsp_t  res_n;
	logic  en_out;
	work_t fin;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign eff0 = eff_res(res0_q, 0);
	assign eff1 = eff_res(res1_q, 1);
	assign eff2 = eff_res(res2_q, 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res0_q <= RES_RESET;
			res1_q <= RES_RESET;
			res2_q <= RES_RESET;
		end else if (wr) begin
			unique case (paddr[3:2])
				REG_RES_DIM_0: res0_q <= pwdata[RES_W-1:0];
				REG_RES_DIM_1: res1_q <= pwdata[RES_W-1:0];
				REG_RES_DIM_2: res2_q <= pwdata[RES_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_RES_DIM_0: prdata = 32'(res0_q);
			REG_RES_DIM_1: prdata = 32'(res1_q);
			REG_RES_DIM_2: prdata = 32'(res2_q);
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		stride2_q <= STRIDE_W'(eff0) * STRIDE_W'(eff1);
		total_q   <= TOTAL_W'(stride2_q) * TOTAL_W'(eff2);
	end

	gdx_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req_valid), .in_ready(req_ready), .in_item(req),
		.eff0(eff0), .eff1(eff1), .eff2(eff2), .total(total_q),
		.out_valid(v[0]), .out_ready(rdy[0]), .out_item(w[0])
	);

	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		localparam int DIM = (i < COORD_W) ? 2 : 1;
		localparam int BIT = COORD_W - 1 - (i % COORD_W);
		logic [STRIDE_W-1:0] stride;
		assign stride = (DIM == 2) ? stride2_q : STRIDE_W'(eff0);
		gdx_cell #(.DIM(DIM), .BIT(BIT)) u_cell (
			.clk(clk), .arst_n(arst_n), .stride(stride),
			.in_valid(v[i]), .in_ready(rdy[i]), .in_item(w[i]),
			.out_valid(v[i+1]), .out_ready(rdy[i+1]), .out_item(w[i+1])
		);
	end

	assign en_out = !out_valid_q || rsp_ready;
	assign rdy[CELLS] = en_out;
	assign fin = w[CELLS];

	always_comb begin
		res_n = '0;
		res_n.out_of_range = fin.oor;
		if (!fin.oor) begin
			if (fin.op == OP_COMBINE) begin
				res_n.out_cell_number = fin.acc + CELL_W'(fin.x0);
			end else begin
				res_n.out_coord_zero = fin.acc[COORD_W-1:0];
				res_n.out_coord_one  = fin.x1;
				res_n.out_coord_two  = fin.x2;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_out) begin
			out_valid_q <= v[CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && v[CELLS]) out_q <= res_n;
	end

	assign rsp_valid = out_valid_q;
	assign rsp = out_q;

`ifndef SYNTH
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.out_of_range |-> rsp.out_cell_number == '0
		&& rsp.out_coord_zero == '0 && rsp.out_coord_one == '0 && rsp.out_coord_two == '0)
		else $error("out of range result carries data");
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.out_cell_number != '0 |-> rsp.out_coord_one == '0
		&& rsp.out_coord_two == '0 && rsp.out_coord_zero == '0)
		else $error("result mixes cell number and coordinates");
	a_stride: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> stride2_q == STRIDE_W'($past(eff0)) * STRIDE_W'($past(eff1)))
		else $error("stride register out of step");
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> rdy[CELLS])
		else $error("output stage stalls while empty");
`endif
endmodule
